### hdl/adcplc_pkg.sv
package adcplc_pkg;

  localparam int unsigned GAIN_MV_DEF    = 16500;
  localparam int unsigned ADC_BITS_DEF   = 12;
  localparam int unsigned CAL_POINTS_DEF = 4;

  localparam int unsigned NUM_PTS    = 4;
  localparam int unsigned PT_IDX_W   = 2;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned APB_ADDR_W = REG_IDX_W + 2;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned MV_W   = 15;
  localparam int unsigned CORR_W = 16;

  typedef logic [MV_W-1:0] mv_t;
  typedef logic signed [CORR_W-1:0] corr_t;

  localparam mv_t   MV_MAX   = '1;
  localparam corr_t CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
  localparam corr_t CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

  localparam mv_t MEAS_RST [NUM_PTS] = '{15'd960, 15'd1700, 15'd2060, 15'd3080};
  localparam mv_t ACT_RST  [NUM_PTS] = '{15'd1720, 15'd2520, 15'd2890, 15'd3930};

endpackage

### hdl/adcplc_if.sv
interface adcplc_in_if #(
  parameter int unsigned SAMPLE_W = adcplc_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface adcplc_out_if;
  logic              valid;
  logic              ready;
  adcplc_pkg::mv_t   raw_mv;
  adcplc_pkg::corr_t corrected_mv;
  logic              table_fault;

  modport source (output valid, output raw_mv, output corrected_mv, output table_fault,
                  input ready);
  modport sink (input valid, input raw_mv, input corrected_mv, input table_fault,
                output ready);
endinterface

### hdl/adc_piecewise_linear_calibration_top.sv
// Converts each ADC code to millivolts, raw = floor(code * GAIN_MV / 2^ADC_BITS) saturated
// to 15 bits, and corrects it through a piecewise-linear table of CAL_POINTS breakpoint
// pairs: interpolation inside the table, extrapolation from the end segments outside it,
// division truncating toward zero and the result saturated to 16 bits signed. If the used
// measured points are not strictly increasing, table_fault is set and the raw value is
// passed through. One item is taken every clock cycle while the output is not stalled.
// Most of the pipeline is the segment divider, which resolves one quotient bit per
// pipeline stage over 17 stages. Every stage holds its item independently, so the input
// keeps accepting items while a result waits at the output until all 23 stages are full.
// Registers sit on the APB port
// at byte address 4*i: measured points 0..3 at 0x00..0x0C and true points 0..3 at
// 0x10..0x1C, 15 bits each; write them only while no item is in flight.
module adc_piecewise_linear_calibration_top #(
  parameter int unsigned GAIN_MV    = adcplc_pkg::GAIN_MV_DEF,
  parameter int unsigned ADC_BITS   = adcplc_pkg::ADC_BITS_DEF,
  parameter int unsigned CAL_POINTS = adcplc_pkg::CAL_POINTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  adcplc_in_if.sink                           samp_i,
  adcplc_out_if.source                        res_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [adcplc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [adcplc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [adcplc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                pready
);

  localparam int unsigned MV_W     = adcplc_pkg::MV_W;
  localparam int unsigned PT_IDX_W = adcplc_pkg::PT_IDX_W;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned PROD_W   = ADC_BITS + GAIN_W;
  localparam int unsigned DIFF_W   = MV_W + 1;
  localparam int unsigned NUM_W    = 2 * DIFF_W;
  localparam int unsigned QW       = 17;
  localparam int unsigned REM_W    = MV_W + QW;
  localparam int unsigned SUM_W    = QW + 2;
  localparam int unsigned NSTG     = QW + 6;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [QW-1:0]     quo;
    adcplc_pkg::mv_t   den;
    adcplc_pkg::mv_t   t0;
    adcplc_pkg::mv_t   raw;
    logic              neg;
    logic              ovf;
    logic              fault;
  } div_t;

  // Configuration registers.
  adcplc_pkg::mv_t meas_q [adcplc_pkg::NUM_PTS];
  adcplc_pkg::mv_t act_q  [adcplc_pkg::NUM_PTS];
  logic [adcplc_pkg::REG_IDX_W-1:0] reg_idx;
  logic                             tbl_sel;
  logic [PT_IDX_W-1:0]              pt_idx;

  assign reg_idx = paddr[adcplc_pkg::APB_ADDR_W-1:2];
  assign tbl_sel = reg_idx[adcplc_pkg::REG_IDX_W-1];
  assign pt_idx  = reg_idx[PT_IDX_W-1:0];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_q <= adcplc_pkg::MEAS_RST;
      act_q  <= adcplc_pkg::ACT_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (tbl_sel) begin
        act_q[pt_idx] <= pwdata[MV_W-1:0];
      end else begin
        meas_q[pt_idx] <= pwdata[MV_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = adcplc_pkg::APB_DATA_W'(tbl_sel ? act_q[pt_idx] : meas_q[pt_idx]);
  end

  // Stage enables: a stage moves when it is empty or its successor moves.
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || res_o.ready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign samp_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= samp_i.valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // Stage 0: scale the sample.
  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q <= PROD_W'(ADC_BITS'(samp_i.adc_sample)) * PROD_W'(GAIN_MV);
    end
  end

  // Stage 1: saturate, check the table and pick the segment.
  logic [GAIN_W-1:0]   raw_full;
  adcplc_pkg::mv_t     raw_s1;
  logic                fault_s1;
  logic [PT_IDX_W-1:0] seg;
  logic [PT_IDX_W-1:0] seg_nxt;
  adcplc_pkg::mv_t     raw1_q, m0_q, m1_q, t0_1_q, t1_q;
  logic                fault1_q;

  always_comb begin
    raw_full = prod_q[PROD_W-1 -: GAIN_W];
    raw_s1   = (raw_full > GAIN_W'(adcplc_pkg::MV_MAX)) ? adcplc_pkg::MV_MAX
                                                        : raw_full[MV_W-1:0];
    fault_s1 = 1'b0;
    for (int i = 0; i < int'(CAL_POINTS) - 1; i++) begin
      if (meas_q[PT_IDX_W'(i)] >= meas_q[PT_IDX_W'(i + 1)]) begin
        fault_s1 = 1'b1;
      end
    end
    seg = PT_IDX_W'(CAL_POINTS - 2);
    for (int i = int'(CAL_POINTS) - 3; i >= 0; i--) begin
      if (raw_s1 <= meas_q[PT_IDX_W'(i + 1)]) begin
        seg = PT_IDX_W'(i);
      end
    end
    seg_nxt = seg + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      raw1_q   <= raw_s1;
      fault1_q <= fault_s1;
      m0_q     <= meas_q[seg];
      m1_q     <= meas_q[seg_nxt];
      t0_1_q   <= act_q[seg];
      t1_q     <= act_q[seg_nxt];
    end
  end

  // Stage 2: segment differences.
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  adcplc_pkg::mv_t          raw2_q, t0_2_q, den2_q;
  logic                     fault2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dx_q     <= $signed({1'b0, raw1_q}) - $signed({1'b0, m0_q});
      dy_q     <= $signed({1'b0, t1_q}) - $signed({1'b0, t0_1_q});
      den2_q   <= m1_q - m0_q;
      raw2_q   <= raw1_q;
      t0_2_q   <= t0_1_q;
      fault2_q <= fault1_q;
    end
  end

  // Stage 3: numerator.
  logic signed [NUM_W-1:0] num_q;
  adcplc_pkg::mv_t         raw3_q, t0_3_q, den3_q;
  logic                    fault3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      num_q    <= dx_q * dy_q;
      raw3_q   <= raw2_q;
      t0_3_q   <= t0_2_q;
      den3_q   <= den2_q;
      fault3_q <= fault2_q;
    end
  end

  // Stage 4: magnitude, sign and quotient overflow.
  div_t dv_q [QW+1];
  div_t dv_s4;

  always_comb begin
    dv_s4.neg   = num_q[NUM_W-1];
    dv_s4.rem   = dv_s4.neg ? REM_W'(-num_q) : REM_W'(num_q);
    dv_s4.ovf   = dv_s4.rem >= (REM_W'(den3_q) << QW);
    dv_s4.quo   = '0;
    dv_s4.den   = den3_q;
    dv_s4.t0    = t0_3_q;
    dv_s4.raw   = raw3_q;
    dv_s4.fault = fault3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      dv_q[0] <= dv_s4;
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int unsigned K = QW - j;
    div_t             dv_d;
    logic [REM_W-1:0] dsh;

    always_comb begin
      dv_d = dv_q[j-1];
      dsh  = REM_W'(dv_q[j-1].den) << K;
      if (dv_q[j-1].rem >= dsh) begin
        dv_d.rem    = dv_q[j-1].rem - dsh;
        dv_d.quo[K] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[4+j]) begin
        dv_q[j] <= dv_d;
      end
    end
  end

  // Output stage: apply sign, add the segment base and saturate, or pass the raw value on a table fault.
  logic signed [QW:0]      qs;
  logic signed [SUM_W-1:0] sum;
  adcplc_pkg::corr_t       corr_d;
  adcplc_pkg::corr_t       corr_q;
  adcplc_pkg::mv_t         raw_q;
  logic                    fault_q;

  always_comb begin
    qs  = dv_q[QW].neg ? -$signed({1'b0, dv_q[QW].quo}) : $signed({1'b0, dv_q[QW].quo});
    sum = $signed(SUM_W'(dv_q[QW].t0)) + SUM_W'(qs);
    if (dv_q[QW].fault) begin
      corr_d = $signed({1'b0, dv_q[QW].raw});
    end else if (dv_q[QW].ovf) begin
      corr_d = dv_q[QW].neg ? adcplc_pkg::CORR_MIN : adcplc_pkg::CORR_MAX;
    end else if (sum > SUM_W'(adcplc_pkg::CORR_MAX)) begin
      corr_d = adcplc_pkg::CORR_MAX;
    end else if (sum < SUM_W'(adcplc_pkg::CORR_MIN)) begin
      corr_d = adcplc_pkg::CORR_MIN;
    end else begin
      corr_d = sum[adcplc_pkg::CORR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      corr_q  <= corr_d;
      raw_q   <= dv_q[QW].raw;
      fault_q <= dv_q[QW].fault;
    end
  end

  assign res_o.valid        = v_q[NSTG-1];
  assign res_o.raw_mv       = raw_q;
  assign res_o.corrected_mv = corr_q;
  assign res_o.table_fault  = fault_q;

endmodule

### sim/adcplc_result_checker.sv
`timescale 1ns / 100ps

module adcplc_result_checker
  import adcplc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  adcplc_in_if                  samp_i,
  adcplc_out_if                 res_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  run_done_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);

  typedef struct packed {
    mv_t   raw_mv;
    corr_t corrected_mv;
    logic  table_fault;
  } cal_result_t;

  cal_result_t expected_q[$];
  mv_t         meas_pt[NUM_PTS];
  mv_t         true_pt[NUM_PTS];
  int unsigned err_cnt = 0;
  logic        end_checked;

  assign errors_o = err_cnt;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_cnt < 40) begin
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    end
    err_cnt++;
  endtask

  function automatic cal_result_t calibrate_code(input logic [ADC_BITS_DEF-1:0] code);
    cal_result_t     r;
    longint unsigned scaled;
    longint          raw;
    longint          m0;
    longint          m1;
    longint          t0;
    longint          t1;
    longint          corr;
    int              seg;
    logic            bad;
    scaled = (64'(code) * 64'(GAIN_MV_DEF)) >> ADC_BITS_DEF;
    if (scaled > 64'(MV_MAX)) begin
      scaled = 64'(MV_MAX);
    end
    raw = longint'(scaled);
    bad = 1'b0;
    for (int i = 0; i + 1 < CAL_POINTS_DEF; i++) begin
      if (meas_pt[i] >= meas_pt[i+1]) begin
        bad = 1'b1;
      end
    end
    seg = 0;
    if (bad) begin
      corr = raw;
    end else begin
      if (raw <= longint'(meas_pt[0])) begin
        seg = 0;
      end else if (raw >= longint'(meas_pt[CAL_POINTS_DEF-1])) begin
        seg = CAL_POINTS_DEF - 2;
      end else begin
        for (int i = CAL_POINTS_DEF - 2; i >= 0; i--) begin
          if (raw >= longint'(meas_pt[i]) && raw <= longint'(meas_pt[i+1])) begin
            seg = i;
          end
        end
      end
      m0 = longint'(meas_pt[seg]);
      m1 = longint'(meas_pt[seg+1]);
      t0 = longint'(true_pt[seg]);
      t1 = longint'(true_pt[seg+1]);
      corr = t0 + ((raw - m0) * (t1 - t0)) / (m1 - m0);
      if (corr > longint'(CORR_MAX)) begin
        corr = longint'(CORR_MAX);
      end else if (corr < longint'(CORR_MIN)) begin
        corr = longint'(CORR_MIN);
      end
    end
    r.raw_mv       = mv_t'(scaled);
    r.corrected_mv = corr_t'(corr);
    r.table_fault  = bad;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    cal_result_t want;
    int unsigned idx;
    if (!rst_ni) begin
      expected_q.delete();
      for (int i = 0; i < NUM_PTS; i++) begin
        meas_pt[i] = MEAS_RST[i];
        true_pt[i] = ACT_RST[i];
      end
      end_checked = 1'b0;
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unrequested result raw_mv", longint'(res_i.raw_mv), -1);
        end else begin
          want = expected_q.pop_front();
          if (res_i.raw_mv !== want.raw_mv) begin
            report_mismatch("raw_mv", longint'(res_i.raw_mv), longint'(want.raw_mv));
          end
          if (res_i.corrected_mv !== want.corrected_mv) begin
            report_mismatch("corrected_mv", longint'($signed(res_i.corrected_mv)),
                            longint'($signed(want.corrected_mv)));
          end
          if (res_i.table_fault !== want.table_fault) begin
            report_mismatch("table_fault", longint'(res_i.table_fault),
                            longint'(want.table_fault));
          end
        end
      end
      if (samp_i.valid && samp_i.ready) begin
        expected_q.push_back(calibrate_code(samp_i.adc_sample));
      end
      if (psel && penable && pwrite && pready) begin
        idx = paddr[APB_ADDR_W-1:2];
        if (idx < NUM_PTS) begin
          meas_pt[idx] = pwdata[MV_W-1:0];
        end else if (idx < 2 * NUM_PTS) begin
          true_pt[idx - NUM_PTS] = pwdata[MV_W-1:0];
        end
      end
      if (run_done_i && !end_checked) begin
        end_checked = 1'b1;
        if (expected_q.size() != 0) begin
          report_mismatch("samples left without result", expected_q.size(), 0);
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import adcplc_pkg::*;

  localparam int     HALF_PERIOD    = 10;
  localparam int     LATENCY_CYCLES = 23;
  localparam int     HOLD_CYCLES    = 300;
  localparam int     DRAIN_LIMIT    = 5000;
  localparam longint TIMEOUT_NS     = 8_000_000;
  localparam int     MEAS_IDX0      = 0;
  localparam int     TRUE_IDX0      = NUM_PTS;
  localparam int     CODE_MAX       = (1 << ADC_BITS_DEF) - 1;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  samp_fire;
  logic                  apb_fire;
  logic                  run_done;
  int unsigned           pending;
  int unsigned           errors;
  bit                    no_idle;
  int                    hold_reqs;
  int                    tbl_meas[NUM_PTS];
  int                    tbl_true[NUM_PTS];

  adcplc_in_if  samp_if ();
  adcplc_out_if res_if ();

  adc_piecewise_linear_calibration_top DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .samp_i  (samp_if.sink),
    .res_o   (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  adcplc_result_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .samp_i     (samp_if),
    .res_i      (res_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .run_done_i (run_done),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("adc_piecewise_linear_calibration_top test failed");
    $finish;
  end

  always_ff @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      samp_fire <= 1'b0;
      apb_fire  <= 1'b0;
    end else begin
      samp_fire <= samp_if.valid && samp_if.ready;
      apb_fire  <= psel && penable && pwrite && pready;
    end
  end

  // The receiver serves each hold request by keeping ready low for a long stretch.
  initial begin
    int served;
    served = 0;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (served != hold_reqs) begin
        served = hold_reqs;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_if.ready <= no_idle || ($urandom_range(99) >= 19);
    end
  end

  function automatic int raw_of_code(input int code);
    return (code * GAIN_MV_DEF) >> ADC_BITS_DEF;
  endfunction

  function automatic logic [ADC_BITS_DEF-1:0] pick_code();
    int roll;
    int code;
    roll = $urandom_range(99);
    if (roll < 40) begin
      code = int'((tbl_meas[$urandom_range(NUM_PTS - 1)] << ADC_BITS_DEF) / GAIN_MV_DEF)
             + int'($urandom_range(3)) - 1;
    end else if (roll < 46) begin
      code = ($urandom_range(1) != 0) ? CODE_MAX : 0;
    end else begin
      code = $urandom_range(CODE_MAX);
    end
    if (code < 0) begin
      code = 0;
    end else if (code > CODE_MAX) begin
      code = CODE_MAX;
    end
    return code[ADC_BITS_DEF-1:0];
  endfunction

  task automatic send_code(input logic [ADC_BITS_DEF-1:0] code);
    samp_if.valid      <= 1'b1;
    samp_if.adc_sample <= code;
    @(negedge clk);
    while (!samp_fire) @(negedge clk);
    if (!no_idle && $urandom_range(99) < 19) begin
      samp_if.valid      <= 1'b0;
      samp_if.adc_sample <= $urandom();
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    samp_if.valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && pending != 0; k++) begin
      @(negedge clk);
    end
  endtask

  task automatic send_random(input int count);
    repeat (count) send_code(pick_code());
  endtask

  task automatic write_reg(input int idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx << 2);
    pwdata  <= ($urandom() & 32'hFFFF_8000) | APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!apb_fire) @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_table();
    for (int i = 0; i < NUM_PTS; i++) begin
      write_reg(MEAS_IDX0 + i, tbl_meas[i]);
      write_reg(TRUE_IDX0 + i, tbl_true[i]);
    end
  endtask

  // Tables that are broken or that drive the correction into both saturation limits.
  task automatic set_fixed_table(input int which);
    case (which)
      0: begin
        tbl_meas = '{0, 0, 0, 0};
        tbl_true = '{12345, 0, 32767, 777};
      end
      1: begin
        tbl_meas = '{32767, 32767, 32767, 32767};
        tbl_true = '{32767, 32767, 32767, 32767};
      end
      2: begin
        tbl_meas = '{3000, 1000, 2000, 4000};
        tbl_true = '{100, 200, 300, 400};
      end
      3: begin
        tbl_meas = '{100, 5000, 5000, 9000};
        tbl_true = '{0, 32767, 16000, 8000};
      end
      4: begin
        tbl_meas = '{0, 1, 2, 3};
        tbl_true = '{32767, 32767, 32767, 0};
      end
      5: begin
        tbl_meas = '{0, 1, 2, 3};
        tbl_true = '{0, 0, 0, 32767};
      end
      6: begin
        tbl_meas = '{16497, 16498, 16499, 32767};
        tbl_true = '{0, 32767, 0, 32767};
      end
      default: begin
        tbl_meas = '{1, 2, 16494, 16495};
        tbl_true = '{32767, 0, 0, 32767};
      end
    endcase
  endtask

  task automatic make_random_table();
    int code;
    int tmp;
    code = $urandom_range(1000);
    for (int i = 0; i < NUM_PTS; i++) begin
      tbl_meas[i] = raw_of_code(code > CODE_MAX ? CODE_MAX : code);
      code += $urandom_range(1, 1300);
      if ($urandom_range(99) < 60) begin
        tmp = tbl_meas[i] + int'($urandom_range(2000));
        tbl_true[i] = (tmp > 32767) ? 32767 : tmp;
      end else begin
        tbl_true[i] = $urandom_range(32767);
      end
    end
    if ($urandom_range(99) < 10) begin
      tbl_meas[NUM_PTS-1] = $urandom_range(16500, 32767);
    end
    if ($urandom_range(99) < 15) begin
      tmp         = tbl_meas[1];
      tbl_meas[1] = tbl_meas[2];
      tbl_meas[2] = tmp;
    end
  endtask

  initial begin
    logic [ADC_BITS_DEF-1:0] directed_codes[$];
    directed_codes = '{12'd0, 12'd1, 12'd2, 12'd4095, 12'd4094, 12'd2048, 12'd2047,
                       12'h555, 12'hAAA, 12'd238, 12'd239, 12'd422, 12'd423, 12'd511,
                       12'd512, 12'd764, 12'd765, 12'd1000, 12'd3000, 12'd100};
    rst_n              = 1'b0;
    samp_if.valid      = 1'b0;
    samp_if.adc_sample = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    run_done           = 1'b0;
    no_idle            = 1'b0;
    hold_reqs          = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (tbl_meas[i]) begin
      tbl_meas[i] = MEAS_RST[i];
      tbl_true[i] = ACT_RST[i];
    end
    foreach (directed_codes[i]) begin
      send_code(directed_codes[i]);
    end

    // Hold the output off long enough that the pipeline fills and the input stalls.
    send_random(40);
    hold_reqs++;
    send_random(120);
    drain();

    for (int p = 0; p < 8; p++) begin
      set_fixed_table(p);
      load_table();
      send_random(80);
      drain();
    end

    for (int p = 0; p < 7; p++) begin
      make_random_table();
      load_table();
      no_idle = (p == 2);
      if (p == 4) begin
        send_random(50);
        drain();
        send_random(50);
      end else begin
        send_random(100);
      end
      drain();
    end
    no_idle = 1'b0;

    repeat (LATENCY_CYCLES + 10) @(negedge clk);
    run_done <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("adc_piecewise_linear_calibration_top test passed");
    end else begin
      $display("adc_piecewise_linear_calibration_top test failed");
    end
    $finish;
  end

endmodule
